// ===== hw/rtl/ffpa_pkg.sv =====
// Package for the first-fit pool allocator: state encoding, operation codes
// and the status bundle passed from the fit unit. No dependencies.
`timescale 1ns / 1ps

package ffpa_pkg;

  // Operation codes carried on the op field
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_SPLIT,
    ST_UNLINK,
    ST_DONE
  } state_t;

  // Outcome of checking one free-list header against the request
  typedef struct packed {
    logic fit;
    logic split;
  } fit_status_t;

endpackage

// ===== hw/rtl/ffpa_fit_unit.sv =====
// Fit check for one free-list header: size compare, split decision and
// remainder arithmetic. Depends on ffpa_pkg.
`timescale 1ns / 1ps

module ffpa_fit_unit #(
  parameter int POOL_BYTES   = 4096,
  parameter int HEADER_BYTES = 16
) (
  input  logic [$clog2(POOL_BYTES):0]   blk_size,
  input  logic [11:0]                   req,
  input  logic [$clog2(POOL_BYTES):0]   cur,
  output ffpa_pkg::fit_status_t         status,
  output logic [$clog2(POOL_BYTES)-1:0] rest_at,
  output logic [$clog2(POOL_BYTES):0]   rest_size,
  output logic [11:0]                   payload
);
  import ffpa_pkg::*;

  localparam int AW = $clog2(POOL_BYTES);
  localparam int LW = AW + 1;
  localparam int SW = ((AW > 12) ? AW : 12) + 2;

  logic [SW-1:0] size_w;
  logic [SW-1:0] req_w;
  logic [SW-1:0] cur_w;
  logic [SW-1:0] hdr_w;
  logic [SW-1:0] need_w;
  logic [SW-1:0] rest_w;
  logic [SW-1:0] pay_w;
  logic [SW-1:0] left_w;

  // Widen every operand so that no sum wraps
  assign size_w = SW'(blk_size);
  assign req_w  = SW'(req);
  assign cur_w  = SW'(cur);
  assign hdr_w  = SW'(HEADER_BYTES);

  // Request plus one header, and where the remainder header would sit
  assign pay_w  = cur_w + hdr_w;
  assign need_w = req_w + hdr_w;
  assign rest_w = pay_w + req_w;
  assign left_w = size_w - need_w;

  assign status.fit   = (size_w >= req_w);
  assign status.split = (size_w >= req_w) && (size_w > need_w) &&
                        (rest_w < SW'(POOL_BYTES));

  assign rest_at   = rest_w[AW-1:0];
  assign rest_size = left_w[LW-1:0];
  assign payload   = pay_w[11:0];

endmodule

// ===== hw/rtl/first_fit_pool_allocator_unit.sv =====
// First-fit pool allocator top level: sequencer, header memories, list head
// and result register. Depends on ffpa_pkg and ffpa_fit_unit.
`timescale 1ns / 1ps

// Allocates and frees blocks of a byte pool of POOL_BYTES bytes, each block
// led by a header of HEADER_BYTES bytes kept in two on-chip memories (size and
// link, one word per byte offset). After reset the block writes the single
// whole-pool header in its init state before it raises in_ready. A free is
// handled in the idle state: it pushes the header onto the list head, or is
// dropped when the address is null or out of range. An allocate walks the free
// list one header at a time through the single memory read port: each header
// visited is read, then compared in the fit unit, and a fit then goes through
// the split and unlink steps as needed. A failed search returns alloc_failed
// with address 0 and leaves the list as it was. Walks are capped at POOL_BYTES
// headers so a list made cyclic by a double free still terminates. The result
// is held in an output register; a new item is taken only when that register
// is empty or is read out in the same cycle, and an allocate stalls at its end
// until that register is free.
module first_fit_pool_allocator_unit #(
  parameter int POOL_BYTES   = 4096,
  parameter int HEADER_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [11:0] request_size,
  input  logic [11:0] payload_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] result_address,
  output logic        alloc_failed
);
  import ffpa_pkg::*;

  localparam int AW = $clog2(POOL_BYTES);
  localparam int LW = AW + 1;
  localparam int VW = AW + 1;
  localparam int SW = ((AW > 12) ? AW : 12) + 2;
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_BYTES);

  state_t state, state_next;

  // Header memories
  logic [LW-1:0] size_mem [POOL_BYTES];
  logic [LW-1:0] link_mem [POOL_BYTES];
  logic [LW-1:0] rd_size;
  logic [LW-1:0] rd_link;

  logic          size_we;
  logic [AW-1:0] size_wa;
  logic [LW-1:0] size_wd;
  logic          link_we;
  logic [AW-1:0] link_wa;
  logic [LW-1:0] link_wd;

  // Walk registers
  logic [LW-1:0] head;
  logic [LW-1:0] cur;
  logic [LW-1:0] prev;
  logic [VW-1:0] visits;
  logic [11:0]   req;
  logic [AW-1:0] rest_at_r;
  logic [LW-1:0] new_link;
  logic [11:0]   res_addr;
  logic          res_fail;

  // Fit unit results
  fit_status_t   fit_st;
  logic [AW-1:0] rest_at;
  logic [LW-1:0] rest_size;
  logic [11:0]   payload;

  // Free decode
  logic [SW-1:0] free_off;
  logic          free_ok;
  logic          accept;
  logic          walk_end;
  logic          out_free;

  ffpa_fit_unit #(
    .POOL_BYTES   (POOL_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_fit (
    .blk_size  (rd_size),
    .req       (req),
    .cur       (cur),
    .status    (fit_st),
    .rest_at   (rest_at),
    .rest_size (rest_size),
    .payload   (payload)
  );

  // Handshake and decode
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign free_off = SW'(payload_address) - SW'(HEADER_BYTES);
  assign free_ok  = (SW'(payload_address) >= SW'(HEADER_BYTES)) &&
                    (free_off < SW'(POOL_BYTES));
  assign walk_end = (cur >= NULL_LINK) || (visits == VW'(POOL_BYTES));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept && (op == OP_ALLOC)) state_next = ST_READ;
      end
      ST_READ: state_next = walk_end ? ST_DONE : ST_EVAL;
      ST_EVAL: begin
        if (!fit_st.fit) begin
          state_next = ST_READ;
        end else if (fit_st.split) begin
          state_next = ST_SPLIT;
        end else begin
          state_next = (prev >= NULL_LINK) ? ST_DONE : ST_UNLINK;
        end
      end
      ST_SPLIT:  state_next = (prev >= NULL_LINK) ? ST_DONE : ST_UNLINK;
      ST_UNLINK: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  // Memory write controls
  always_comb begin
    size_we = 1'b0;
    size_wa = '0;
    size_wd = '0;
    link_we = 1'b0;
    link_wa = '0;
    link_wd = '0;
    case (state)
      ST_INIT: begin
        size_we = 1'b1;
        size_wd = LW'(POOL_BYTES - HEADER_BYTES);
        link_we = 1'b1;
        link_wd = NULL_LINK;
      end
      ST_IDLE: begin
        if (accept && (op == OP_FREE) && free_ok) begin
          link_we = 1'b1;
          link_wa = free_off[AW-1:0];
          link_wd = head;
        end
      end
      ST_EVAL: begin
        if (fit_st.split) begin
          size_we = 1'b1;
          size_wa = rest_at;
          size_wd = rest_size;
          link_we = 1'b1;
          link_wa = rest_at;
          link_wd = rd_link;
        end
      end
      ST_SPLIT: begin
        size_we = 1'b1;
        size_wa = cur[AW-1:0];
        size_wd = LW'(req);
        link_we = 1'b1;
        link_wa = cur[AW-1:0];
        link_wd = {1'b0, rest_at_r};
      end
      ST_UNLINK: begin
        link_we = 1'b1;
        link_wa = prev[AW-1:0];
        link_wd = new_link;
      end
      default: begin
        size_we = 1'b0;
        link_we = 1'b0;
      end
    endcase
  end

  // Header memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (size_we) size_mem[size_wa] <= size_wd;
    if (link_we) link_mem[link_wa] <= link_wd;
    rd_size <= size_mem[cur[AW-1:0]];
    rd_link <= link_mem[cur[AW-1:0]];
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // List head
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && (op == OP_FREE) && free_ok) head <= LW'(free_off);
        end
        ST_EVAL: begin
          if (fit_st.fit && !fit_st.split && (prev >= NULL_LINK)) head <= rd_link;
        end
        ST_SPLIT: begin
          if (prev >= NULL_LINK) head <= {1'b0, rest_at_r};
        end
        default: head <= head;
      endcase
    end
  end

  // Walk datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur      <= head;
        prev     <= NULL_LINK;
        visits   <= '0;
        req      <= request_size;
        res_addr <= '0;
        res_fail <= 1'b1;
      end
      ST_EVAL: begin
        if (fit_st.fit) begin
          res_addr  <= payload;
          res_fail  <= 1'b0;
          rest_at_r <= rest_at;
          new_link  <= rd_link;
        end else begin
          prev   <= cur;
          cur    <= rd_link;
          visits <= visits + VW'(1);
        end
      end
      ST_SPLIT: new_link <= {1'b0, rest_at_r};
      default: cur <= cur;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((accept && (op == OP_FREE)) || ((state == ST_DONE) && out_free)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (op == OP_FREE)) begin
      result_address <= '0;
      alloc_failed   <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      result_address <= res_fail ? 12'd0 : res_addr;
      alloc_failed   <= res_fail;
    end
  end

  // Checks
  a_alloc_starts_walk: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_ALLOC)) |=> (state == ST_READ))
    else $error("allocate did not start a list walk");

  a_fail_is_null: assert property (@(posedge clk) disable iff (rst)
    (out_valid && alloc_failed) |-> (result_address == 12'd0))
    else $error("failed allocate returned a non-null address");

  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) |-> (visits < VW'(POOL_BYTES)))
    else $error("list walk ran past its bound");

  a_no_write_on_miss: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EVAL) && !fit_st.fit) |-> (!size_we && !link_we))
    else $error("header written while skipping a block that does not fit");

endmodule
